/* hdl/pbc_pkg.sv */
`timescale 1ns / 1ps
// pbc_pkg: shared types, character codes and the symbol classifier for the
// pileup base counter; depends on nothing

package pbc_pkg;

    localparam int PBC_COUNT_WIDTH = 16;
    localparam int PBC_MAX_INDEL   = 1023;
    localparam int PBC_OUT_WIDTH   = 16;
    localparam int PBC_CFG_WIDTH   = 7;
    localparam int PBC_SYM_WIDTH   = 8;

    // phred offset of ascii qualities
    localparam logic [8:0] PHRED_OFFSET = 9'd33;

    // counter slots
    localparam int NUM_BASE = 6;
    localparam int IDX_A    = 0;
    localparam int IDX_C    = 1;
    localparam int IDX_G    = 2;
    localparam int IDX_T    = 3;
    localparam int IDX_REF  = 4;
    localparam int IDX_STAR = 5;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UC     = 8'h43;
    localparam logic [7:0] CH_UG     = 8'h47;
    localparam logic [7:0] CH_UT     = 8'h54;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LC     = 8'h63;
    localparam logic [7:0] CH_LG     = 8'h67;
    localparam logic [7:0] CH_LT     = 8'h74;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_SKIP_ONE = 2'd1,
        MODE_DIGITS   = 2'd2,
        MODE_SKIP_N   = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        SYM_DOLLAR,
        SYM_CARET,
        SYM_MINUS,
        SYM_PLUS,
        SYM_DIGIT,
        SYM_REF,
        SYM_A,
        SYM_C,
        SYM_G,
        SYM_T,
        SYM_STAR,
        SYM_OTHER
    } t_sym;

    function automatic t_sym classify(input logic [7:0] sym);
        t_sym cls;
        if (sym == CH_DOLLAR)                          cls = SYM_DOLLAR;
        else if (sym == CH_CARET)                      cls = SYM_CARET;
        else if (sym == CH_MINUS)                      cls = SYM_MINUS;
        else if (sym == CH_PLUS)                       cls = SYM_PLUS;
        else if (sym >= CH_ZERO && sym <= CH_NINE)     cls = SYM_DIGIT;
        else if (sym == CH_DOT || sym == CH_COMMA)     cls = SYM_REF;
        else if (sym == CH_UA || sym == CH_LA)         cls = SYM_A;
        else if (sym == CH_UC || sym == CH_LC)         cls = SYM_C;
        else if (sym == CH_UG || sym == CH_LG)         cls = SYM_G;
        else if (sym == CH_UT || sym == CH_LT)         cls = SYM_T;
        else if (sym == CH_STAR)                       cls = SYM_STAR;
        else                                           cls = SYM_OTHER;
        return cls;
    endfunction

endpackage

/* hdl/pileup_base_counter.sv */
`timescale 1ns / 1ps
// pileup_base_counter: top level with input register, snapshot and output
// handshakes; depends on pbc_pkg, pbc_parser and pbc_result
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  input   | in        | i_valid / o_stall  | i_symbol i_quality i_ref_base i_last
//  result  | out       | o_valid / i_stall  | o_count_* o_ins/del_starts o_filtered_coverage
//  config  | in        | i_cfg_we           | i_cfg_wdata (min_base_quality)
//
// one character beat is taken every cycle while o_stall is low; the parser state and
// counters update from the input register as each beat is consumed, so the parse loop
// sets the rate; a last beat raises o_valid once it has passed the snapshot register
// and then the output register (the clamp and reference add sit before it)
// non-last beats keep flowing while a result waits; input stalls only when a last
// beat sits in the input register while the snapshot and output both hold results
// and the receiver stalls
// reset is synchronous, active low; it clears the parser, counters, valid flags
// and min_base_quality; no clearing pass is needed

module pileup_base_counter #(
    parameter int COUNT_WIDTH      = pbc_pkg::PBC_COUNT_WIDTH,
    parameter int MAX_INDEL_LENGTH = pbc_pkg::PBC_MAX_INDEL
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [pbc_pkg::PBC_CFG_WIDTH-1:0]  i_cfg_wdata,
    // input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [pbc_pkg::PBC_SYM_WIDTH-1:0]  i_symbol,
    input  logic [pbc_pkg::PBC_SYM_WIDTH-1:0]  i_quality,
    input  logic [pbc_pkg::PBC_SYM_WIDTH-1:0]  i_ref_base,
    input  logic                               i_last,
    // result channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [pbc_pkg::PBC_OUT_WIDTH-1:0]  o_count_a,
    output logic [pbc_pkg::PBC_OUT_WIDTH-1:0]  o_count_c,
    output logic [pbc_pkg::PBC_OUT_WIDTH-1:0]  o_count_g,
    output logic [pbc_pkg::PBC_OUT_WIDTH-1:0]  o_count_t,
    output logic [pbc_pkg::PBC_OUT_WIDTH-1:0]  o_count_ref_match,
    output logic [pbc_pkg::PBC_OUT_WIDTH-1:0]  o_count_star,
    output logic [pbc_pkg::PBC_OUT_WIDTH-1:0]  o_ins_starts,
    output logic [pbc_pkg::PBC_OUT_WIDTH-1:0]  o_del_starts,
    output logic [pbc_pkg::PBC_OUT_WIDTH-1:0]  o_filtered_coverage
);
    import pbc_pkg::*;

    // configuration register
    logic [PBC_CFG_WIDTH-1:0] r_min_qual;

    // input register
    logic                     r_in_valid, n_in_valid;
    logic [PBC_SYM_WIDTH-1:0] r_in_symbol, r_in_quality, r_in_ref_base;
    logic                     r_in_last;

    // snapshot and output flags
    logic r_snap_valid, n_snap_valid;
    logic r_out_valid, n_out_valid;

    logic in_take;   // beat accepted from upstream
    logic in_adv;    // input register consumed by the parser
    logic snap_adv;  // snapshot moves into the output register

    logic [NUM_BASE-1:0][COUNT_WIDTH-1:0] snap_base;
    logic [COUNT_WIDTH-1:0]               snap_ins, snap_del, snap_cov;
    logic [PBC_SYM_WIDTH-1:0]             snap_ref_base;

    assign snap_adv = r_snap_valid && (!r_out_valid || !i_stall);
    // a last beat needs the snapshot slot free or emptying this cycle
    assign in_adv   = r_in_valid && (!r_in_last || !r_snap_valid || snap_adv);
    assign o_stall  = r_in_valid && !in_adv;
    assign in_take  = i_valid && !o_stall;
    assign o_valid  = r_out_valid;

    assign n_in_valid   = in_take || (r_in_valid && !in_adv);
    assign n_snap_valid = (in_adv && r_in_last) || (r_snap_valid && !snap_adv);
    assign n_out_valid  = snap_adv || (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_qual   <= '0;
            r_in_valid   <= 1'b0;
            r_snap_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_qual <= i_cfg_wdata;
            end
            r_in_valid   <= n_in_valid;
            r_snap_valid <= n_snap_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload of the input register, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_symbol   <= i_symbol;
            r_in_quality  <= i_quality;
            r_in_ref_base <= i_ref_base;
            r_in_last     <= i_last;
        end
    end

    pbc_parser #(
        .COUNT_WIDTH      (COUNT_WIDTH),
        .MAX_INDEL_LENGTH (MAX_INDEL_LENGTH)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_consume       (in_adv),
        .i_symbol        (r_in_symbol),
        .i_quality       (r_in_quality),
        .i_ref_base      (r_in_ref_base),
        .i_last          (r_in_last),
        .i_min_qual      (r_min_qual),
        .o_snap_base     (snap_base),
        .o_snap_ins      (snap_ins),
        .o_snap_del      (snap_del),
        .o_snap_cov      (snap_cov),
        .o_snap_ref_base (snap_ref_base)
    );

    pbc_result #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_result (
        .i_clk               (i_clk),
        .i_load              (snap_adv),
        .i_base              (snap_base),
        .i_ins               (snap_ins),
        .i_del               (snap_del),
        .i_cov               (snap_cov),
        .i_ref_base          (snap_ref_base),
        .o_count_a           (o_count_a),
        .o_count_c           (o_count_c),
        .o_count_g           (o_count_g),
        .o_count_t           (o_count_t),
        .o_count_ref_match   (o_count_ref_match),
        .o_count_star        (o_count_star),
        .o_ins_starts        (o_ins_starts),
        .o_del_starts        (o_del_starts),
        .o_filtered_coverage (o_filtered_coverage)
    );

`ifndef SYNTHESIS
    // a last beat never overwrites a snapshot that has not moved on
    a_snap_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_adv && r_in_last && r_snap_valid && !snap_adv))
        else $error("snapshot overwritten before transfer");

    // a waiting snapshot stays put
    a_snap_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_snap_valid && !snap_adv) |=> r_snap_valid)
        else $error("snapshot lost while output blocked");

    // a snapshot transfer shows up as a result on the next cycle
    a_snap_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        snap_adv |=> o_valid)
        else $error("snapshot transfer did not raise o_valid");

    // a stalled input register holds its beat
    a_in_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> (r_in_valid && $stable(r_in_last) && $stable(r_in_symbol)))
        else $error("stalled input register changed");

    // no result straight out of reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !r_snap_valid && !r_in_valid))
        else $error("valid flags not cleared by reset");
`endif

endmodule

/* hdl/pbc_parser.sv */
`timescale 1ns / 1ps
// pbc_parser: parse state machine, saturating counters and the end-of-string
// snapshot; depends on pbc_pkg

module pbc_parser #(
    parameter int COUNT_WIDTH      = pbc_pkg::PBC_COUNT_WIDTH,
    parameter int MAX_INDEL_LENGTH = pbc_pkg::PBC_MAX_INDEL
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_consume,
    input  logic [pbc_pkg::PBC_SYM_WIDTH-1:0]            i_symbol,
    input  logic [pbc_pkg::PBC_SYM_WIDTH-1:0]            i_quality,
    input  logic [pbc_pkg::PBC_SYM_WIDTH-1:0]            i_ref_base,
    input  logic                                         i_last,
    input  logic [pbc_pkg::PBC_CFG_WIDTH-1:0]            i_min_qual,
    output logic [pbc_pkg::NUM_BASE-1:0][COUNT_WIDTH-1:0] o_snap_base,
    output logic [COUNT_WIDTH-1:0]                       o_snap_ins,
    output logic [COUNT_WIDTH-1:0]                       o_snap_del,
    output logic [COUNT_WIDTH-1:0]                       o_snap_cov,
    output logic [pbc_pkg::PBC_SYM_WIDTH-1:0]            o_snap_ref_base
);
    import pbc_pkg::*;

    localparam int LW = $clog2(MAX_INDEL_LENGTH + 1);
    localparam int NW = LW + 4;
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    t_mode                                 r_mode, n_mode;
    logic [LW-1:0]                         r_len, n_len;
    logic [LW-1:0]                         r_rem, n_rem;
    logic [NUM_BASE-1:0][COUNT_WIDTH-1:0]  r_base, n_base;
    logic [COUNT_WIDTH-1:0]                r_ins, n_ins;
    logic [COUNT_WIDTH-1:0]                r_del, n_del;
    logic [COUNT_WIDTH-1:0]                r_cov, n_cov;

    t_sym                 sym_class;
    logic                 qual_ok;
    logic                 normal_act;
    logic [NUM_BASE-1:0]  inc_base;
    logic                 inc_ins, inc_del, inc_cov;
    logic [NW-1:0]        len_acc;
    logic [LW-1:0]        len_sat;
    logic [LW-1:0]        rem_dec;
    logic [LW-1:0]        len_m1;

    assign sym_class = classify(i_symbol);
    assign qual_ok   = {1'b0, i_quality} >= (9'(i_min_qual) + PHRED_OFFSET);

    // len * 10 + digit as shift-add
    assign len_acc = (NW'(r_len) << 3) + (NW'(r_len) << 1) + NW'(i_symbol[3:0]);
    assign len_sat = (len_acc > NW'(MAX_INDEL_LENGTH)) ? LW'(MAX_INDEL_LENGTH)
                                                        : len_acc[LW-1:0];
    assign rem_dec = (r_rem != '0) ? r_rem - 1'b1 : r_rem;
    assign len_m1  = r_len - 1'b1;

    always_comb begin
        n_mode     = r_mode;
        n_len      = r_len;
        n_rem      = r_rem;
        normal_act = 1'b0;
        inc_base   = '0;
        inc_ins    = 1'b0;
        inc_del    = 1'b0;
        inc_cov    = 1'b0;

        unique case (r_mode)
            MODE_SKIP_ONE: begin
                n_mode = MODE_NORMAL;
            end
            MODE_SKIP_N: begin
                n_rem = rem_dec;
                if (rem_dec == '0) begin
                    n_mode = MODE_NORMAL;
                end
            end
            MODE_DIGITS: begin
                if (sym_class == SYM_DIGIT) begin
                    n_len = len_sat;
                end else if (r_len == '0) begin
                    n_mode     = MODE_NORMAL;
                    normal_act = 1'b1;
                end else begin
                    // this beat is the first skipped indel base
                    n_rem  = len_m1;
                    n_len  = '0;
                    n_mode = (len_m1 != '0) ? MODE_SKIP_N : MODE_NORMAL;
                end
            end
            MODE_NORMAL: begin
                normal_act = 1'b1;
            end
        endcase

        if (normal_act) begin
            case (sym_class)
                SYM_DOLLAR: begin
                end
                SYM_CARET: begin
                    n_mode = MODE_SKIP_ONE;
                end
                SYM_MINUS: begin
                    inc_del = 1'b1;
                    n_len   = '0;
                    n_mode  = MODE_DIGITS;
                end
                SYM_PLUS: begin
                    inc_ins = 1'b1;
                    n_len   = '0;
                    n_mode  = MODE_DIGITS;
                end
                default: begin
                    if (qual_ok) begin
                        inc_cov = 1'b1;
                        case (sym_class)
                            SYM_REF:  inc_base[IDX_REF]  = 1'b1;
                            SYM_A:    inc_base[IDX_A]    = 1'b1;
                            SYM_C:    inc_base[IDX_C]    = 1'b1;
                            SYM_G:    inc_base[IDX_G]    = 1'b1;
                            SYM_T:    inc_base[IDX_T]    = 1'b1;
                            SYM_STAR: inc_base[IDX_STAR] = 1'b1;
                            default:  ;
                        endcase
                    end
                end
            endcase
        end
    end

    // saturating increments
    always_comb begin
        for (int k = 0; k < NUM_BASE; k++) begin
            n_base[k] = (inc_base[k] && r_base[k] != CMAX) ? r_base[k] + 1'b1 : r_base[k];
        end
        n_ins = (inc_ins && r_ins != CMAX) ? r_ins + 1'b1 : r_ins;
        n_del = (inc_del && r_del != CMAX) ? r_del + 1'b1 : r_del;
        n_cov = (inc_cov && r_cov != CMAX) ? r_cov + 1'b1 : r_cov;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_len  <= '0;
            r_rem  <= '0;
            r_base <= '0;
            r_ins  <= '0;
            r_del  <= '0;
            r_cov  <= '0;
        end else if (i_consume) begin
            if (i_last) begin
                // string finished: parser and counters start afresh
                r_mode <= MODE_NORMAL;
                r_len  <= '0;
                r_rem  <= '0;
                r_base <= '0;
                r_ins  <= '0;
                r_del  <= '0;
                r_cov  <= '0;
            end else begin
                r_mode <= n_mode;
                r_len  <= n_len;
                r_rem  <= n_rem;
                r_base <= n_base;
                r_ins  <= n_ins;
                r_del  <= n_del;
                r_cov  <= n_cov;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_consume && i_last) begin
            o_snap_base     <= n_base;
            o_snap_ins      <= n_ins;
            o_snap_del      <= n_del;
            o_snap_cov      <= n_cov;
            o_snap_ref_base <= i_ref_base;
        end
    end

endmodule

/* hdl/pbc_result.sv */
`timescale 1ns / 1ps
// pbc_result: folds reference matches into the reference base count and
// clamps every field into the output register; depends on pbc_pkg

module pbc_result #(
    parameter int COUNT_WIDTH = pbc_pkg::PBC_COUNT_WIDTH
) (
    input  logic                                          i_clk,
    input  logic                                          i_load,
    input  logic [pbc_pkg::NUM_BASE-1:0][COUNT_WIDTH-1:0] i_base,
    input  logic [COUNT_WIDTH-1:0]                        i_ins,
    input  logic [COUNT_WIDTH-1:0]                        i_del,
    input  logic [COUNT_WIDTH-1:0]                        i_cov,
    input  logic [pbc_pkg::PBC_SYM_WIDTH-1:0]             i_ref_base,
    output logic [pbc_pkg::PBC_OUT_WIDTH-1:0]             o_count_a,
    output logic [pbc_pkg::PBC_OUT_WIDTH-1:0]             o_count_c,
    output logic [pbc_pkg::PBC_OUT_WIDTH-1:0]             o_count_g,
    output logic [pbc_pkg::PBC_OUT_WIDTH-1:0]             o_count_t,
    output logic [pbc_pkg::PBC_OUT_WIDTH-1:0]             o_count_ref_match,
    output logic [pbc_pkg::PBC_OUT_WIDTH-1:0]             o_count_star,
    output logic [pbc_pkg::PBC_OUT_WIDTH-1:0]             o_ins_starts,
    output logic [pbc_pkg::PBC_OUT_WIDTH-1:0]             o_del_starts,
    output logic [pbc_pkg::PBC_OUT_WIDTH-1:0]             o_filtered_coverage
);
    import pbc_pkg::*;

    // wide enough for a count plus the matches and for the clamp limit
    localparam int SW = (COUNT_WIDTH + 1 > PBC_OUT_WIDTH + 1) ? COUNT_WIDTH + 1
                                                              : PBC_OUT_WIDTH + 1;
    localparam logic [SW-1:0] OUT_MAX = SW'({PBC_OUT_WIDTH{1'b1}});

    function automatic logic [PBC_OUT_WIDTH-1:0] clamp(input logic [SW-1:0] v);
        return (v > OUT_MAX) ? OUT_MAX[PBC_OUT_WIDTH-1:0] : v[PBC_OUT_WIDTH-1:0];
    endfunction

    logic [SW-1:0] ref_ext;
    logic [SW-1:0] sum_a, sum_c, sum_g, sum_t;

    assign ref_ext = SW'(i_base[IDX_REF]);
    assign sum_a = SW'(i_base[IDX_A]) + ((i_ref_base == CH_UA) ? ref_ext : '0);
    assign sum_c = SW'(i_base[IDX_C]) + ((i_ref_base == CH_UC) ? ref_ext : '0);
    assign sum_g = SW'(i_base[IDX_G]) + ((i_ref_base == CH_UG) ? ref_ext : '0);
    assign sum_t = SW'(i_base[IDX_T]) + ((i_ref_base == CH_UT) ? ref_ext : '0);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_count_a           <= clamp(sum_a);
            o_count_c           <= clamp(sum_c);
            o_count_g           <= clamp(sum_g);
            o_count_t           <= clamp(sum_t);
            o_count_ref_match   <= clamp(ref_ext);
            o_count_star        <= clamp(SW'(i_base[IDX_STAR]));
            o_ins_starts        <= clamp(SW'(i_ins));
            o_del_starts        <= clamp(SW'(i_del));
            o_filtered_coverage <= clamp(SW'(i_cov));
        end
    end

endmodule

/* tb/sv/pileup_base_counter_tb.sv */
`timescale 1ns / 1ps
// pileup_base_counter_tb: self-checking bench for the pileup base counter,
// directed table then random samples; depends on pbc_pkg and pileup_base_counter

module pileup_base_counter_tb;
    import pbc_pkg::*;

    // drain after the last expected result: three stages plus margin
    localparam int DRAIN_CYCLES     = 8;
    localparam int END_CYCLES       = 16;
    // receiver hold-off used to back the block up
    localparam int HOLD_CYCLES      = 300;
    // beats per random phase, three phases
    localparam int RANDOM_PER_PHASE = 235;
    localparam int OUT_MAX          = (1 << PBC_OUT_WIDTH) - 1;

    // one result beat, field order matches the port list
    typedef struct packed {
        logic [PBC_OUT_WIDTH-1:0] count_a;
        logic [PBC_OUT_WIDTH-1:0] count_c;
        logic [PBC_OUT_WIDTH-1:0] count_g;
        logic [PBC_OUT_WIDTH-1:0] count_t;
        logic [PBC_OUT_WIDTH-1:0] count_ref_match;
        logic [PBC_OUT_WIDTH-1:0] count_star;
        logic [PBC_OUT_WIDTH-1:0] ins_starts;
        logic [PBC_OUT_WIDTH-1:0] del_starts;
        logic [PBC_OUT_WIDTH-1:0] filtered_coverage;
    } t_counts;

    // one row of the directed table; typed rows carry their own answer
    typedef struct {
        logic [7:0] sym;
        logic [7:0] qual;
        logic [7:0] refb;
        logic       last;
        logic       typed;
        t_counts    want;
    } t_dir_row;

    // ------------------------------------------------------------------
    // block ports, every input known from time zero
    // ------------------------------------------------------------------
    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_cfg_we    = 1'b0;
    logic [PBC_CFG_WIDTH-1:0] i_cfg_wdata = '0;
    logic                     i_valid     = 1'b0;
    logic                     o_stall;
    logic [PBC_SYM_WIDTH-1:0] i_symbol    = '0;
    logic [PBC_SYM_WIDTH-1:0] i_quality   = '0;
    logic [PBC_SYM_WIDTH-1:0] i_ref_base  = '0;
    logic                     i_last      = 1'b0;
    logic                     o_valid;
    logic                     i_stall     = 1'b0;
    logic [PBC_OUT_WIDTH-1:0] o_count_a;
    logic [PBC_OUT_WIDTH-1:0] o_count_c;
    logic [PBC_OUT_WIDTH-1:0] o_count_g;
    logic [PBC_OUT_WIDTH-1:0] o_count_t;
    logic [PBC_OUT_WIDTH-1:0] o_count_ref_match;
    logic [PBC_OUT_WIDTH-1:0] o_count_star;
    logic [PBC_OUT_WIDTH-1:0] o_ins_starts;
    logic [PBC_OUT_WIDTH-1:0] o_del_starts;
    logic [PBC_OUT_WIDTH-1:0] o_filtered_coverage;

    // typed answer travels with its beat so the scoreboard sees it on acceptance
    logic    row_typed = 1'b0;
    t_counts row_want  = '0;

    // ------------------------------------------------------------------
    // bench control
    // ------------------------------------------------------------------
    int idle_pct  = 0;      // sender gap chance per beat, percent
    int stall_pct = 0;      // receiver stall chance per cycle, percent
    int hold_len  = 0;      // non-zero asks the receiver for a long hold-off
    int n_errors  = 0;
    int n_results = 0;

    t_counts  expected_counts[$];
    t_dir_row dir_rows[$];

    // ------------------------------------------------------------------
    // predictor state: parser, counters and its own copy of the register
    // ------------------------------------------------------------------
    logic [PBC_CFG_WIDTH-1:0]   min_qual  = '0;
    t_mode                      pmode     = MODE_NORMAL;
    int                         digit_len = 0;
    int                         skip_left = 0;
    logic [PBC_COUNT_WIDTH-1:0] tally [NUM_BASE] = '{default: '0};
    logic [PBC_COUNT_WIDTH-1:0] ins_cnt   = '0;
    logic [PBC_COUNT_WIDTH-1:0] del_cnt   = '0;
    logic [PBC_COUNT_WIDTH-1:0] cov_cnt   = '0;

    // read bases and reference nucleotides drawn by the random part
    logic [7:0] base_set [11] = '{CH_DOT, CH_COMMA, CH_UA, CH_UC, CH_UG, CH_UT,
                                  CH_LA, CH_LC, CH_LG, CH_LT, CH_STAR};
    logic [7:0] nuc_set  [4]  = '{CH_UA, CH_UC, CH_UG, CH_UT};

    pileup_base_counter uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_symbol            (i_symbol),
        .i_quality           (i_quality),
        .i_ref_base          (i_ref_base),
        .i_last              (i_last),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_count_a           (o_count_a),
        .o_count_c           (o_count_c),
        .o_count_g           (o_count_g),
        .o_count_t           (o_count_t),
        .o_count_ref_match   (o_count_ref_match),
        .o_count_star        (o_count_star),
        .o_ins_starts        (o_ins_starts),
        .o_del_starts        (o_del_starts),
        .o_filtered_coverage (o_filtered_coverage)
    );

    // 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // counters stick at their ceiling
    function automatic logic [PBC_COUNT_WIDTH-1:0] bump(logic [PBC_COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // outputs are 16 bits whatever the counter width, sums included
    function automatic logic [PBC_OUT_WIDTH-1:0] clamp_out(longint unsigned v);
        return (v > OUT_MAX) ? '1 : v[PBC_OUT_WIDTH-1:0];
    endfunction

    // a read base only counts once its ascii quality clears limit + 33
    function automatic void count_read_base(logic [7:0] s, logic [7:0] q);
        if (int'(q) < int'(min_qual) + int'(PHRED_OFFSET))
            return;
        case (s)
            CH_DOT, CH_COMMA: tally[IDX_REF]  = bump(tally[IDX_REF]);
            CH_UA, CH_LA:     tally[IDX_A]    = bump(tally[IDX_A]);
            CH_UC, CH_LC:     tally[IDX_C]    = bump(tally[IDX_C]);
            CH_UG, CH_LG:     tally[IDX_G]    = bump(tally[IDX_G]);
            CH_UT, CH_LT:     tally[IDX_T]    = bump(tally[IDX_T]);
            CH_STAR:          tally[IDX_STAR] = bump(tally[IDX_STAR]);
            default: ;
        endcase
        // anything that got past the quality gate is coverage, stray digits too
        cov_cnt = bump(cov_cnt);
    endfunction

    // a character met while no skip or length is in progress
    function automatic void parse_plain(logic [7:0] s, logic [7:0] q);
        case (s)
            CH_DOLLAR: ;
            CH_CARET:  pmode = MODE_SKIP_ONE;
            CH_MINUS: begin
                del_cnt   = bump(del_cnt);
                digit_len = 0;
                pmode     = MODE_DIGITS;
            end
            CH_PLUS: begin
                ins_cnt   = bump(ins_cnt);
                digit_len = 0;
                pmode     = MODE_DIGITS;
            end
            default:   count_read_base(s, q);
        endcase
    endfunction

    // one character beat in; returns 1 with the counts when it closes a sample
    function automatic bit parse_char(input logic [7:0] s, input logic [7:0] q,
                                      input logic [7:0] rb, input logic lst,
                                      output t_counts res);
        longint unsigned a, c, g, t, r;
        int              nl;
        res = '0;
        case (pmode)
            MODE_SKIP_ONE: pmode = MODE_NORMAL;
            MODE_SKIP_N: begin
                if (skip_left > 0)
                    skip_left--;
                if (skip_left == 0)
                    pmode = MODE_NORMAL;
            end
            MODE_DIGITS: begin
                if (s >= CH_ZERO && s <= CH_NINE) begin
                    nl        = digit_len * 10 + (int'(s) - int'(CH_ZERO));
                    digit_len = (nl > PBC_MAX_INDEL) ? PBC_MAX_INDEL : nl;
                end else if (digit_len == 0) begin
                    // bare marker or zero length: this character parses normally
                    pmode = MODE_NORMAL;
                    parse_plain(s, q);
                end else begin
                    // first indel base is this one
                    skip_left = digit_len - 1;
                    digit_len = 0;
                    pmode     = (skip_left > 0) ? MODE_SKIP_N : MODE_NORMAL;
                end
            end
            default: parse_plain(s, q);
        endcase

        if (!lst)
            return 0;

        a = tally[IDX_A];
        c = tally[IDX_C];
        g = tally[IDX_G];
        t = tally[IDX_T];
        r = tally[IDX_REF];
        // only upper-case reference letters take the matches
        case (rb)
            CH_UA:   a += r;
            CH_UC:   c += r;
            CH_UG:   g += r;
            CH_UT:   t += r;
            default: ;
        endcase
        res.count_a           = clamp_out(a);
        res.count_c           = clamp_out(c);
        res.count_g           = clamp_out(g);
        res.count_t           = clamp_out(t);
        res.count_ref_match   = clamp_out(r);
        res.count_star        = clamp_out(tally[IDX_STAR]);
        res.ins_starts        = clamp_out(ins_cnt);
        res.del_starts        = clamp_out(del_cnt);
        res.filtered_coverage = clamp_out(cov_cnt);

        // parser and counters start afresh for the next sample, limit kept
        pmode     = MODE_NORMAL;
        digit_len = 0;
        skip_left = 0;
        tally     = '{default: '0};
        ins_cnt   = '0;
        del_cnt   = '0;
        cov_cnt   = '0;
        return 1;
    endfunction

    // ------------------------------------------------------------------
    // scoreboard
    // ------------------------------------------------------------------

    // one line per mismatch, every one counted
    task automatic log_mismatch(string msg);
        n_errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [PBC_OUT_WIDTH-1:0] got_v,
                               logic [PBC_OUT_WIDTH-1:0] want_v);
        if (got_v !== want_v)
            log_mismatch($sformatf("result %0d %s got %0d want %0d",
                                   n_results, name, got_v, want_v));
    endtask

    // accepted beats feed the predictor, accepted results are checked in order
    always @(posedge i_clk) begin : scoreboard
        t_counts pred;
        t_counts got;
        t_counts want;
        if (i_rst_n) begin
            if (i_cfg_we)
                min_qual = i_cfg_wdata;
            if (i_valid && !o_stall) begin
                if (parse_char(i_symbol, i_quality, i_ref_base, i_last, pred))
                    expected_counts.push_back(row_typed ? row_want : pred);
            end
            if (o_valid && !i_stall) begin
                got = {o_count_a, o_count_c, o_count_g, o_count_t, o_count_ref_match,
                       o_count_star, o_ins_starts, o_del_starts, o_filtered_coverage};
                if (expected_counts.size() == 0) begin
                    log_mismatch($sformatf("result %0d with nothing pending", n_results));
                end else begin
                    want = expected_counts.pop_front();
                    check_field("count_a",           got.count_a,           want.count_a);
                    check_field("count_c",           got.count_c,           want.count_c);
                    check_field("count_g",           got.count_g,           want.count_g);
                    check_field("count_t",           got.count_t,           want.count_t);
                    check_field("count_ref_match",   got.count_ref_match,
                                want.count_ref_match);
                    check_field("count_star",        got.count_star,        want.count_star);
                    check_field("ins_starts",        got.ins_starts,        want.ins_starts);
                    check_field("del_starts",        got.del_starts,        want.del_starts);
                    check_field("filtered_coverage", got.filtered_coverage,
                                want.filtered_coverage);
                end
                n_results++;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, or a long counted hold-off on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                n        = hold_len;
                hold_len = 0;
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // offers one beat, after an optional gap, and returns on the edge it is taken
    task automatic send_char(logic [7:0] s, logic [7:0] q, logic [7:0] rb, logic lst,
                             logic typed, t_counts want);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_symbol   <= s;
        i_quality  <= q;
        i_ref_base <= rb;
        i_last     <= lst;
        row_typed  <= typed;
        row_want   <= want;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    // stop offering, wait for every pending result, then let the pipe empty
    task automatic drain(int extra);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_counts.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // register write only once the block has gone quiet
    task automatic write_min_qual(logic [PBC_CFG_WIDTH-1:0] v);
        drain(DRAIN_CYCLES);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic void add_row(logic [7:0] s, logic [7:0] q, logic [7:0] rb,
                                    logic lst = 1'b0, logic typed = 1'b0,
                                    t_counts want = '0);
        t_dir_row row;
        row.sym   = s;
        row.qual  = q;
        row.refb  = rb;
        row.last  = lst;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    // half the time right at the gate, half anywhere in the byte
    function automatic logic [7:0] pick_qual();
        int v;
        if ($urandom_range(1))
            return 8'($urandom_range(255));
        v = int'(min_qual) + int'(PHRED_OFFSET) + $urandom_range(4) - 2;
        return 8'((v < 0) ? 0 : v);
    endfunction

    // random samples, mostly well formed, some pure noise, some cut short
    task automatic run_random(int goal);
        logic [7:0] chars[$];
        logic [7:0] rb;
        string      digits;
        int         counted;
        int         n_tok;
        int         kind;
        int         len;
        int         cut;
        counted = 0;
        while (counted < goal) begin
            chars.delete();
            n_tok   = $urandom_range(12, 1);
            if ($urandom_range(99) < 10) begin
                // noise: any byte at all
                repeat (n_tok) chars.push_back(8'($urandom_range(255)));
            end else begin
                repeat (n_tok) begin
                    kind = $urandom_range(99);
                    if (kind < 50) begin
                        chars.push_back(base_set[$urandom_range(10)]);
                    end else if (kind < 60) begin
                        chars.push_back(8'($urandom_range(255)));
                    end else if (kind < 67) begin
                        chars.push_back(CH_DOLLAR);
                    end else if (kind < 75) begin
                        // read start and its mapping quality
                        chars.push_back(CH_CARET);
                        chars.push_back(8'($urandom_range(255)));
                    end else begin
                        chars.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
                        kind = $urandom_range(99);
                        len  = 0;
                        if (kind >= 10) begin
                            // zero or short length
                            if (kind < 20)
                                len = 0;
                            else
                                len = $urandom_range(12, 1);
                            digits = $sformatf("%0d", len);
                            if ($urandom_range(9) == 0)
                                digits = {"0", digits};
                            foreach (digits[i])
                                chars.push_back(digits[i]);
                        end
                        if (len > PBC_MAX_INDEL)
                            len = PBC_MAX_INDEL;
                        repeat (len) chars.push_back(base_set[$urandom_range(10)]);
                    end
                end
            end
            // broken sample: last lands anywhere, mid-skip included
            if ($urandom_range(99) < 15) begin
                cut = $urandom_range(chars.size(), 1);
                while (chars.size() > cut)
                    void'(chars.pop_back());
            end
            for (int k = 0; k < chars.size(); k++) begin
                if (k == chars.size() - 1)
                    rb = ($urandom_range(3) != 0) ? nuc_set[$urandom_range(3)]
                                                  : 8'($urandom_range(255));
                else
                    rb = 8'($urandom_range(255));
                send_char(chars[k], pick_qual(), rb, k == chars.size() - 1, 1'b0, '0);
            end
            counted += chars.size();
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, limit still at its reset value of zero
        // single '.' right at the gate, reference A takes the match
        add_row(CH_DOT, 8'd33, CH_UA, 1'b1, 1'b1,
                '{count_a: 16'd1, count_ref_match: 16'd1, filtered_coverage: 16'd1,
                  default: 16'd0});
        // one below the gate: nothing counted
        add_row(CH_UA, 8'd32, CH_UC, 1'b1, 1'b1, '0);
        // read start eats the next byte, then every kind of read base but A
        add_row(CH_CARET, 8'd0, 8'd0);
        add_row("~", 8'd255, 8'd255);
        add_row(CH_LC, 8'd255, CH_UA);
        add_row(CH_DOLLAR, 8'd0, 8'd0);
        add_row(CH_UG, 8'd40, 8'd0);
        add_row(CH_LT, 8'd40, 8'd0);
        add_row(CH_STAR, 8'd40, 8'd0);
        add_row(8'h00, 8'd40, 8'd0);       // nul is a read base
        add_row("7", 8'd40, 8'd0);         // stray digit is a read base
        add_row(8'hFF, 8'd0, 8'd0);        // top byte, quality too low
        add_row(CH_COMMA, 8'd40, CH_UG, 1'b1);
        // insertion of two, zero-length deletion, bare insertion marker
        add_row(CH_PLUS, 8'd0, 8'd0);
        add_row("2", 8'd0, 8'd0);
        add_row(CH_UA, 8'd60, 8'd0);
        add_row(CH_UC, 8'd60, 8'd0);
        add_row(CH_LG, 8'd60, 8'd0);
        add_row(CH_MINUS, 8'd0, 8'd0);
        add_row(CH_ZERO, 8'd0, 8'd0);
        add_row(CH_LT, 8'd60, 8'd0);
        add_row(CH_PLUS, 8'd0, 8'd0);
        add_row(CH_LA, 8'd60, CH_UT, 1'b1);
        // last while a length is being read
        add_row(CH_MINUS, 8'd0, 8'd0);
        add_row(CH_NINE, 8'd0, CH_UT, 1'b1, 1'b1, '{del_starts: 16'd1, default: 16'd0});
        // last on a read start, then the parser must be back to normal
        add_row(CH_CARET, 8'd90, 8'd0, 1'b1, 1'b1, '0);
        add_row(CH_UA, 8'd33, 8'd255, 1'b1, 1'b1,
                '{count_a: 16'd1, filtered_coverage: 16'd1, default: 16'd0});
        // length past the ceiling: only the ceiling's worth of bases is skipped
        add_row(CH_PLUS, 8'd0, 8'd0);
        add_row("1", 8'd0, 8'd0);
        add_row("0", 8'd0, 8'd0);
        add_row("3", 8'd0, 8'd0);
        add_row("0", 8'd0, 8'd0);
        for (int k = 0; k < PBC_MAX_INDEL; k++)
            add_row(CH_UA, 8'd60, 8'd0);
        add_row(CH_UC, 8'd60, CH_UA, 1'b1, 1'b1,
                '{count_c: 16'd1, ins_starts: 16'd1, filtered_coverage: 16'd1,
                  default: 16'd0});

        idle_pct  = 25;
        stall_pct = 62;
        foreach (dir_rows[i])
            send_char(dir_rows[i].sym, dir_rows[i].qual, dir_rows[i].refb,
                      dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);

        // limit of 93, sender gaps light, receiver stalls heavy
        write_min_qual(7'd93);
        run_random(RANDOM_PER_PHASE);

        // lowest limit, roles swapped
        write_min_qual(7'd0);
        idle_pct  = 62;
        stall_pct = 25;
        run_random(RANDOM_PER_PHASE);

        // mid limit, no idling; receiver first holds off so the block backs up
        write_min_qual(7'd37);
        idle_pct  = 0;
        stall_pct = 0;
        hold_len  = HOLD_CYCLES;
        run_random(RANDOM_PER_PHASE);

        drain(END_CYCLES);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin : watchdog
        #(200_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule
